### sv/ssp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants for the size string parser
// Parse phases, character codes and the unit suffix shift amounts.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 63;
  localparam int unsigned DigitW = 4;

  // Width of value * 10 + digit before the overflow check.
  localparam int unsigned MulW = ValueW + 4;

  // Suffix scale factors: 2^10, 2^20 and 2^30.
  localparam int unsigned ShiftK = 10;
  localparam int unsigned ShiftM = 20;
  localparam int unsigned ShiftG = 30;

  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChZero    = 8'h30;
  localparam logic [CharW-1:0] ChNine    = 8'h39;
  localparam logic [CharW-1:0] ChCaseBit = 8'h20;
  localparam logic [CharW-1:0] ChLowerK  = 8'h6b;
  localparam logic [CharW-1:0] ChLowerM  = 8'h6d;
  localparam logic [CharW-1:0] ChLowerG  = 8'h67;
  localparam logic [CharW-1:0] ChLowerB  = 8'h62;
  localparam logic [CharW-1:0] ChLowerY  = 8'h79;
  localparam logic [CharW-1:0] ChLowerT  = 8'h74;
  localparam logic [CharW-1:0] ChLowerE  = 8'h65;
  localparam logic [CharW-1:0] ChLowerS  = 8'h73;

  typedef enum logic [3:0] {
    PH_INIT  = 4'd0,
    PH_NUM   = 4'd1,
    PH_K     = 4'd2,
    PH_M     = 4'd3,
    PH_G     = 4'd4,
    PH_B     = 4'd5,
    PH_BY    = 4'd6,
    PH_BYT   = 4'd7,
    PH_BYTE  = 4'd8,
    PH_BYTES = 4'd9,
    PH_ERR   = 4'd10
  } phase_e;

endpackage
`default_nettype wire

### sv/size_suffix_string_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// size_suffix_string_parser: size string parser with k/m/g unit suffix
//
// Characters arrive one per request on the input channel (valid/ready).
// Spaces are skipped. Digits build the value, an optional k, m or g scales it
// by 2^10, 2^20 or 2^30, and b, byte or bytes may follow a suffix. A request
// with last_item_i set closes the string and produces exactly one result
// request: size_value_o and parse_ok_o, with the value forced to zero on error.
// A request with has_char_i low carries no character.
//
// Throughput is one character per cycle, as long as a closing request is not
// held for the result register; the per-character update (a multiply by ten
// plus digit, or a fixed shift, with an overflow check) is combinational
// after the input register. A closing request goes through the input register
// and then the output register, which holds its result.
// When the receiver stalls, the input register keeps taking characters that
// do not end a string; a closing request waits in the input register until
// the output register frees up. Reset empties both registers and returns the
// parser to the start of a new string.
// ----------------------------------------------------------------------------
module size_suffix_string_parser (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [ssp_pkg::CharW-1:0]    char_code_i,
  input  wire logic                         has_char_i,
  input  wire logic                         last_item_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [ssp_pkg::ValueW-1:0]        size_value_o,
  output logic                              parse_ok_o
);

  // Input register.
  logic                      s1_valid_q;
  logic [ssp_pkg::CharW-1:0] s1_char_q;
  logic                      s1_has_q;
  logic                      s1_last_q;
  logic                      s1_go;

  // Parser state.
  ssp_pkg::phase_e            phase_q, phase_d;
  logic [ssp_pkg::ValueW-1:0] acc_q, acc_d;

  // Result register.
  logic                       out_valid_q, out_valid_d;
  logic [ssp_pkg::ValueW-1:0] out_value_q, out_value_d;
  logic                       out_ok_q, out_ok_d;

  // Character decode and arithmetic.
  logic                       consume;
  logic                       is_digit;
  logic [ssp_pkg::CharW-1:0]  ch_low;
  logic [ssp_pkg::DigitW-1:0] digit;
  logic [ssp_pkg::MulW-1:0]   mul_sum;
  logic                       mul_ovf;
  logic                       ovf_k, ovf_m, ovf_g;
  ssp_pkg::phase_e            phase_new;
  logic [ssp_pkg::ValueW-1:0] acc_new;
  logic                       end_ok;

  // A closing request needs a free result slot; anything else moves on.
  assign s1_go      = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_char_q <= char_code_i;
      s1_has_q  <= has_char_i;
      s1_last_q <= last_item_i;
    end
  end

  always_comb begin
    consume  = s1_has_q && (s1_char_q != ssp_pkg::ChSpace);
    is_digit = (s1_char_q >= ssp_pkg::ChZero) && (s1_char_q <= ssp_pkg::ChNine);
    // Folding in the case bit matches exactly the two cases of a letter.
    ch_low   = s1_char_q | ssp_pkg::ChCaseBit;
    digit    = s1_char_q[ssp_pkg::DigitW-1:0];
    mul_sum  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
             + {{(ssp_pkg::MulW-ssp_pkg::DigitW){1'b0}}, digit};
    mul_ovf  = |mul_sum[ssp_pkg::MulW-1:ssp_pkg::ValueW];
    ovf_k    = |acc_q[ssp_pkg::ValueW-1:ssp_pkg::ValueW-ssp_pkg::ShiftK];
    ovf_m    = |acc_q[ssp_pkg::ValueW-1:ssp_pkg::ValueW-ssp_pkg::ShiftM];
    ovf_g    = |acc_q[ssp_pkg::ValueW-1:ssp_pkg::ValueW-ssp_pkg::ShiftG];
  end

  // Next phase and value for one character.
  always_comb begin
    phase_new = ssp_pkg::PH_ERR;
    acc_new   = acc_q;
    unique case (phase_q)
      ssp_pkg::PH_INIT, ssp_pkg::PH_NUM: begin
        if (is_digit) begin
          if (!mul_ovf) begin
            phase_new = ssp_pkg::PH_NUM;
            acc_new   = mul_sum[ssp_pkg::ValueW-1:0];
          end
        end else if (phase_q == ssp_pkg::PH_NUM) begin
          if (ch_low == ssp_pkg::ChLowerK && !ovf_k) begin
            phase_new = ssp_pkg::PH_K;
            acc_new   = acc_q << ssp_pkg::ShiftK;
          end else if (ch_low == ssp_pkg::ChLowerM && !ovf_m) begin
            phase_new = ssp_pkg::PH_M;
            acc_new   = acc_q << ssp_pkg::ShiftM;
          end else if (ch_low == ssp_pkg::ChLowerG && !ovf_g) begin
            phase_new = ssp_pkg::PH_G;
            acc_new   = acc_q << ssp_pkg::ShiftG;
          end
        end
      end
      ssp_pkg::PH_K, ssp_pkg::PH_M, ssp_pkg::PH_G: begin
        if (ch_low == ssp_pkg::ChLowerB) phase_new = ssp_pkg::PH_B;
      end
      ssp_pkg::PH_B: begin
        if (ch_low == ssp_pkg::ChLowerY) phase_new = ssp_pkg::PH_BY;
      end
      ssp_pkg::PH_BY: begin
        if (ch_low == ssp_pkg::ChLowerT) phase_new = ssp_pkg::PH_BYT;
      end
      ssp_pkg::PH_BYT: begin
        if (ch_low == ssp_pkg::ChLowerE) phase_new = ssp_pkg::PH_BYTE;
      end
      ssp_pkg::PH_BYTE: begin
        if (ch_low == ssp_pkg::ChLowerS) phase_new = ssp_pkg::PH_BYTES;
      end
      default: begin
        phase_new = ssp_pkg::PH_ERR;
      end
    endcase
    if (!consume) begin
      phase_new = phase_q;
      acc_new   = acc_q;
    end
  end

  // Ending check, state update and result capture.
  always_comb begin
    unique case (phase_new)
      ssp_pkg::PH_NUM, ssp_pkg::PH_K, ssp_pkg::PH_M, ssp_pkg::PH_G,
      ssp_pkg::PH_B, ssp_pkg::PH_BYTE, ssp_pkg::PH_BYTES: end_ok = 1'b1;
      default: end_ok = 1'b0;
    endcase

    phase_d     = phase_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    out_ok_d    = out_ok_q;
    if (s1_go) begin
      if (s1_last_q) begin
        phase_d     = ssp_pkg::PH_INIT;
        acc_d       = '0;
        out_valid_d = 1'b1;
        out_value_d = end_ok ? acc_new : '0;
        out_ok_d    = end_ok;
      end else begin
        phase_d = phase_new;
        acc_d   = acc_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ssp_pkg::PH_INIT;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_ok_q    <= out_ok_d;
  end

  assign out_valid_o  = out_valid_q;
  assign size_value_o = out_value_q;
  assign parse_ok_o   = out_ok_q;

  // A rejected string always reports a zero size.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !parse_ok_o) |-> (size_value_o == '0))
    else $error("error result with nonzero size");

  // The start phase never carries a partial value.
  a_init_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ssp_pkg::PH_INIT) |-> (acc_q == '0))
    else $error("start phase with nonzero accumulator");

  // Closing a string produces a result and restarts the parser.
  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_last_q) |=> (out_valid_q && phase_q == ssp_pkg::PH_INIT))
    else $error("string end did not restart the parser");

  // An empty input register never blocks the input channel.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with empty input register");

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the size string parser
// Feeds size strings one character per request, predicts the parsed size and
// the accept flag for every closing request, and checks each result in order.
// Directed strings cover the accepted forms, the error cases and the overflow
// edges. Random strings mix well-formed sizes, broken endings and noise under
// random stalls on both channels, except in a back-to-back run without stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [63:0] ValMax        = {1'b0, {63{1'b1}}};
  localparam int          WatchdogLimit = 2000;
  localparam int          RandomTarget  = 600;
  localparam int          SettleCycles  = 10;

  typedef struct packed {
    logic [ssp_pkg::ValueW-1:0] value;
    logic                       ok;
  } size_result_t;

  typedef enum int {
    MutNone,
    MutCutEnding,
    MutDigitAfterUnit,
    MutUnitT,
    MutStrayByte,
    MutTrailingByte
  } mutation_e;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [ssp_pkg::CharW-1:0]  char_code_i;
  logic                       has_char_i;
  logic                       last_item_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [ssp_pkg::ValueW-1:0] size_value_o;
  logic                       parse_ok_o;

  // Predictor state for the string being parsed.
  ssp_pkg::phase_e   parse_ph;
  logic [63:0]       run_value;

  size_result_t              pending_sizes[$];
  size_result_t              want;
  logic [ssp_pkg::CharW-1:0] text_q[$];
  bit                        end_alone;
  bit                        steady_mode;
  int                        requests_sent;
  int                        strings_sent;
  int                        results_checked;
  int                        rejected_seen;
  int                        mismatches;
  int                        quiet_cycles;

  size_suffix_string_parser uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .has_char_i   (has_char_i),
    .last_item_i  (last_item_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .size_value_o (size_value_o),
    .parse_ok_o   (parse_ok_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic same_letter(input logic [ssp_pkg::CharW-1:0] c,
                                       input logic [ssp_pkg::CharW-1:0] lower);
    return (c == lower) || (c == lower - ssp_pkg::ChCaseBit);
  endfunction

  // Advances the parse by one accepted request and queues the size that a
  // closing request yields.
  function automatic void predict_size(input logic [ssp_pkg::CharW-1:0] c,
                                       input logic has, input logic last);
    logic            digit;
    logic [63:0]     d;
    int unsigned     unit_shift;
    ssp_pkg::phase_e unit_ph;
    size_result_t    res;
    digit = (c >= ssp_pkg::ChZero) && (c <= ssp_pkg::ChNine);
    d = {56'd0, c - ssp_pkg::ChZero};
    unit_shift = 0;
    unit_ph = ssp_pkg::PH_ERR;
    if (same_letter(c, ssp_pkg::ChLowerK)) begin
      unit_shift = ssp_pkg::ShiftK;
      unit_ph = ssp_pkg::PH_K;
    end else if (same_letter(c, ssp_pkg::ChLowerM)) begin
      unit_shift = ssp_pkg::ShiftM;
      unit_ph = ssp_pkg::PH_M;
    end else if (same_letter(c, ssp_pkg::ChLowerG)) begin
      unit_shift = ssp_pkg::ShiftG;
      unit_ph = ssp_pkg::PH_G;
    end
    if (has && c != ssp_pkg::ChSpace) begin
      case (parse_ph)
        ssp_pkg::PH_INIT, ssp_pkg::PH_NUM: begin
          if (digit) begin
            if (run_value > (ValMax - d) / 10) begin
              parse_ph = ssp_pkg::PH_ERR;
            end else begin
              run_value = run_value * 10 + d;
              parse_ph = ssp_pkg::PH_NUM;
            end
          end else if (parse_ph == ssp_pkg::PH_NUM && unit_shift != 0) begin
            if (run_value > (ValMax >> unit_shift)) begin
              parse_ph = ssp_pkg::PH_ERR;
            end else begin
              run_value = run_value << unit_shift;
              parse_ph = unit_ph;
            end
          end else begin
            parse_ph = ssp_pkg::PH_ERR;
          end
        end
        ssp_pkg::PH_K, ssp_pkg::PH_M, ssp_pkg::PH_G:
          parse_ph = same_letter(c, ssp_pkg::ChLowerB) ? ssp_pkg::PH_B : ssp_pkg::PH_ERR;
        ssp_pkg::PH_B:
          parse_ph = same_letter(c, ssp_pkg::ChLowerY) ? ssp_pkg::PH_BY : ssp_pkg::PH_ERR;
        ssp_pkg::PH_BY:
          parse_ph = same_letter(c, ssp_pkg::ChLowerT) ? ssp_pkg::PH_BYT : ssp_pkg::PH_ERR;
        ssp_pkg::PH_BYT:
          parse_ph = same_letter(c, ssp_pkg::ChLowerE) ? ssp_pkg::PH_BYTE : ssp_pkg::PH_ERR;
        ssp_pkg::PH_BYTE:
          parse_ph = same_letter(c, ssp_pkg::ChLowerS) ? ssp_pkg::PH_BYTES : ssp_pkg::PH_ERR;
        default: parse_ph = ssp_pkg::PH_ERR;
      endcase
    end
    if (last) begin
      case (parse_ph)
        ssp_pkg::PH_NUM, ssp_pkg::PH_K, ssp_pkg::PH_M, ssp_pkg::PH_G,
        ssp_pkg::PH_B, ssp_pkg::PH_BYTE, ssp_pkg::PH_BYTES: res.ok = 1'b1;
        default: res.ok = 1'b0;
      endcase
      res.value = res.ok ? run_value[ssp_pkg::ValueW-1:0] : '0;
      pending_sizes.push_back(res);
      parse_ph = ssp_pkg::PH_INIT;
      run_value = '0;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high.
  task automatic send_request(input logic [ssp_pkg::CharW-1:0] c, input logic has,
                              input logic last);
    while (!steady_mode && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    has_char_i  <= has;
    last_item_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_size(c, has, last);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input bit end_sep);
    bit sep;
    sep = end_sep || (text_q.size() == 0);
    for (int i = 0; i < text_q.size(); i++) begin
      // An occasional request without a character must change nothing.
      if ($urandom_range(19) == 0) send_request(8'($urandom_range(255)), 1'b0, 1'b0);
      send_request(text_q[i], 1'b1, !sep && (i == text_q.size() - 1));
    end
    if (sep) send_request(8'($urandom_range(255)), 1'b0, 1'b1);
    strings_sent++;
  endtask

  task automatic load_text(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic put_char(input logic [ssp_pkg::CharW-1:0] c);
    if ($urandom_range(9) == 0) text_q.push_back(ssp_pkg::ChSpace);
    text_q.push_back(c);
  endtask

  task automatic put_letter(input logic [ssp_pkg::CharW-1:0] lower);
    put_char($urandom_range(1) ? lower : lower - ssp_pkg::ChCaseBit);
  endtask

  // Builds one random size string in text_q: mostly well-formed sizes, some
  // with a broken ending or a stray byte, and some plain noise.
  task automatic build_size_text(input bit near_limit);
    int unsigned               kind;
    int unsigned               n;
    int unsigned               sfx;
    int unsigned               tail_len;
    int unsigned               tail_choice[4];
    logic [ssp_pkg::CharW-1:0] tail_ch[5];
    logic [63:0]               big;
    string                     num;
    mutation_e                 mut;
    tail_choice = '{0, 1, 4, 5};
    tail_ch = '{ssp_pkg::ChLowerB, ssp_pkg::ChLowerY, ssp_pkg::ChLowerT,
                ssp_pkg::ChLowerE, ssp_pkg::ChLowerS};
    text_q.delete();
    end_alone = ($urandom_range(3) == 0);
    kind = near_limit ? 50 : $urandom_range(99);
    if (kind < 12) begin
      n = $urandom_range(5);
      repeat (n) text_q.push_back(8'($urandom_range(255)));
      return;
    end
    sfx = $urandom_range(3);
    if (near_limit || kind < 17) begin
      // Values around the largest one that the chosen unit still allows.
      big = (ValMax >> (10 * sfx)) + 64'($urandom_range(3)) - 64'($urandom_range(3));
      num = $sformatf("%0d", big);
    end else begin
      n = ($urandom_range(9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
      num = "";
      repeat (n) num = {num, $sformatf("%0d", $urandom_range(9))};
    end
    for (int i = 0; i < num.len(); i++) put_char(num[i]);
    case (sfx)
      1: put_letter(ssp_pkg::ChLowerK);
      2: put_letter(ssp_pkg::ChLowerM);
      3: put_letter(ssp_pkg::ChLowerG);
      default: ;
    endcase
    tail_len = 0;
    if (sfx != 0 || $urandom_range(7) == 0) tail_len = tail_choice[$urandom_range(3)];
    mut = MutNone;
    if (kind >= 80) mut = mutation_e'($urandom_range(MutCutEnding, MutTrailingByte));
    if (mut == MutCutEnding) tail_len = $urandom_range(2, 3);
    for (int i = 0; i < tail_len; i++) put_letter(tail_ch[i]);
    case (mut)
      MutDigitAfterUnit: put_char(ssp_pkg::ChZero + 8'($urandom_range(9)));
      MutUnitT:          put_letter(ssp_pkg::ChLowerT);
      MutStrayByte:      text_q.insert($urandom_range(text_q.size()),
                                       8'($urandom_range(255)));
      MutTrailingByte:   put_char(8'($urandom_range(255)));
      default: ;
    endcase
    if ($urandom_range(9) == 0) text_q.push_back(ssp_pkg::ChSpace);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_sizes.size() != 0);
  endtask

  task automatic test_basic_forms();
    load_text("0");
    send_text(1'b1);
    load_text(" 7K");
    send_text(1'b0);
    load_text("3mB");
    send_text(1'b0);
    load_text("");
    send_text(1'b1);
  endtask

  task automatic test_error_cases();
    load_text("1t");
    send_text(1'b0);
    load_text("5b");
    send_text(1'b0);
    load_text("4kby");
    send_text(1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b1);
    strings_sent++;
  endtask

  task automatic test_value_limits();
    load_text("9999999999g");
    send_text(1'b0);
    load_text("8589934591G");
    send_text(1'b1);
    repeat (10) begin
      build_size_text(1'b1);
      send_text(end_alone);
    end
  endtask

  task automatic test_drain_pause();
    load_text("42kbytes");
    send_text(1'b0);
    hold_until_drained();
    load_text("7 Gbyte");
    send_text(1'b0);
    hold_until_drained();
  endtask

  task automatic test_back_to_back();
    steady_mode = 1'b1;
    repeat (25) begin
      build_size_text(1'b0);
      send_text(end_alone);
    end
    steady_mode = 1'b0;
  endtask

  task automatic test_random_strings();
    int strings;
    strings = 0;
    while (requests_sent < RandomTarget) begin
      build_size_text(1'b0);
      send_text(end_alone);
      strings++;
      if (strings % 60 == 0) hold_until_drained();
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    char_code_i   = '0;
    has_char_i    = 1'b0;
    last_item_i   = 1'b0;
    out_ready_i   = 1'b0;
    steady_mode   = 1'b0;
    parse_ph      = ssp_pkg::PH_INIT;
    run_value     = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_basic_forms();
    test_error_cases();
    test_value_limits();
    test_drain_pause();
    test_back_to_back();
    test_random_strings();

    hold_until_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_sizes.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_sizes.size());
      mismatches++;
    end
    $display("Run covered %0d strings and %0d input requests.",
             strings_sent, requests_sent);
    $display("Checked %0d results, %0d of them rejected strings; %0d mismatches.",
             results_checked, rejected_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  always @(negedge clk_i) begin
    if (steady_mode) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 22);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (!parse_ok_o) rejected_seen++;
      if (pending_sizes.size() == 0) begin
        $display("%0t: result with none expected: size_value %0d parse_ok %0b",
                 $time, size_value_o, parse_ok_o);
        mismatches++;
      end else begin
        want = pending_sizes.pop_front();
        if (size_value_o !== want.value) begin
          $display("%0t: size_value expected %0d, got %0d",
                   $time, want.value, size_value_o);
          mismatches++;
        end
        if (parse_ok_o !== want.ok) begin
          $display("%0t: parse_ok expected %0b, got %0b", $time, want.ok, parse_ok_o);
          mismatches++;
        end
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WatchdogLimit) begin
      $display("%0t: no request moved for %0d cycles", $time, WatchdogLimit);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial quiet_cycles = 0;
  initial mismatches = 0;
  initial requests_sent = 0;
  initial strings_sent = 0;
  initial results_checked = 0;
  initial rejected_seen = 0;

endmodule

### files.f
sv/ssp_pkg.sv
sv/size_suffix_string_parser.sv
verif/tb_top.sv
